/* hdl/csba_pkg.sv */
`default_nettype none
package csba_pkg;

  localparam int NUM_CHUNKS_DEF = 1024;

  localparam int ADDR_W  = 48;
  localparam int LEN_W   = 41;
  localparam int SHIFT_W = 5;
  localparam int LIMIT_W = 31;
  localparam int CNT_W   = 32;
  localparam int TOTAL_W = 64;
  localparam int CFG_W   = 48;
  localparam int CFG_IDX_W = 2;

  localparam logic [ADDR_W-1:0]  WINDOW_BASE_RST  = '0;
  localparam logic [LEN_W-1:0]   WINDOW_BYTES_RST = '0;
  localparam logic [SHIFT_W-1:0] CHUNK_SHIFT_RST  = 5'd21;
  localparam logic [LIMIT_W-1:0] CHUNK_LIMIT_RST  = 31'd2097152;

  localparam logic FUNC_ADD    = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_BASE  = 2'd0,
    REG_WINDOW_BYTES = 2'd1,
    REG_CHUNK_SHIFT  = 2'd2,
    REG_CHUNK_LIMIT  = 2'd3
  } csba_reg_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_LIMIT = 2'd2
  } csba_status_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic calc_off;
    logic calc_end;
    logic calc_idx;
    logic chk;
    logic idx_first;
    logic idx_inc;
    logic wr;
    logic finish;
  } csba_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_fail;
    logic piece_fail;
    logic at_last;
  } csba_stat_t;

endpackage
`default_nettype wire

/* hdl/csba_in_if.sv */
`default_nettype none
interface csba_in_if;
  import csba_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [ADDR_W-1:0] seg_addr;
  logic [LEN_W-1:0]  seg_len;
  logic              with_pa;

  modport source (output valid, output func, output seg_addr, output seg_len,
                  output with_pa, input ready);
  modport sink (input valid, input func, input seg_addr, input seg_len,
                input with_pa, output ready);
endinterface
`default_nettype wire

/* hdl/csba_out_if.sv */
`default_nettype none
interface csba_out_if;
  import csba_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [TOTAL_W-1:0] backed_total;

  modport source (output valid, output status, output backed_total, input ready);
  modport sink (input valid, input status, input backed_total, output ready);
endinterface
`default_nettype wire

/* hdl/csba_ctrl.sv */
`default_nettype none
module csba_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire                  out_ready,
  input  csba_pkg::csba_stat_t stat,
  output csba_pkg::csba_cmd_t  cmd
);
  import csba_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_OFF,
    S_END,
    S_IDX,
    S_CHK_RD,
    S_CHK_CMP,
    S_UPD_RD,
    S_UPD_WR,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_OFF;
        end
      end
      S_OFF: begin
        cmd.calc_off = 1'b1;
        state_next   = S_END;
      end
      S_END: begin
        cmd.calc_end = 1'b1;
        state_next   = S_IDX;
      end
      S_IDX: begin
        cmd.calc_idx = 1'b1;
        state_next   = stat.range_fail ? S_FINISH : S_CHK_RD;
      end
      S_CHK_RD: begin
        state_next = S_CHK_CMP;
      end
      S_CHK_CMP: begin
        cmd.chk = 1'b1;
        if (stat.piece_fail) begin
          state_next = S_FINISH;
        end else if (stat.at_last) begin
          cmd.idx_first = 1'b1;
          state_next    = S_UPD_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_CHK_RD;
        end
      end
      S_UPD_RD: begin
        state_next = S_UPD_WR;
      end
      S_UPD_WR: begin
        cmd.wr = 1'b1;
        if (stat.at_last) begin
          state_next = S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_UPD_RD;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/csba_dp.sv */
`default_nettype none
module csba_dp #(
  parameter int NUM_CHUNKS = csba_pkg::NUM_CHUNKS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_write,
  input  wire  [csba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [csba_pkg::CFG_W-1:0]       cfg_data,
  input  wire                              func,
  input  wire  [csba_pkg::ADDR_W-1:0]      seg_addr,
  input  wire  [csba_pkg::LEN_W-1:0]       seg_len,
  input  wire                              with_pa,
  input  csba_pkg::csba_cmd_t              cmd,
  output csba_pkg::csba_stat_t             stat,
  output logic [1:0]                       status,
  output logic [csba_pkg::TOTAL_W-1:0]     backed_total
);
  import csba_pkg::*;

  localparam int IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

  logic [ADDR_W-1:0]  window_base;
  logic [LEN_W-1:0]   window_bytes;
  logic [SHIFT_W-1:0] chunk_shift;
  logic [LIMIT_W-1:0] chunk_limit;

  logic [CNT_W-1:0] mem [NUM_CHUNKS];
  logic [CNT_W-1:0] rdata;

  logic               func_q;
  logic [ADDR_W-1:0]  addr_q;
  logic [LEN_W-1:0]   len_q;
  logic               with_pa_q;
  logic [ADDR_W-1:0]  off_q;
  logic               lt_base_q;
  logic               len_zero_q;
  logic [ADDR_W:0]    end_q;
  logic               win_fail_q;
  logic               range_fail_q;
  logic               limit_fail_q;
  logic               single_q;
  logic [CNT_W-1:0]   pf_q;
  logic [CNT_W-1:0]   pl_q;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   first_idx;
  logic [IDX_W-1:0]   last_idx;
  logic [TOTAL_W-1:0] backed;

  logic [ADDR_W:0]    off_diff;
  logic [ADDR_W:0]    end_sum;
  logic [LEN_W-1:0]   end_m1;
  logic [LEN_W-1:0]   first_full;
  logic [LEN_W-1:0]   last_full;
  logic               range_now;
  logic [CNT_W-1:0]   csize;
  logic [CNT_W-1:0]   cmask;
  logic [CNT_W-1:0]   piece;
  logic [CNT_W:0]     sum_chk;
  logic               mem_we;
  logic [CNT_W-1:0]   wdata;
  logic [TOTAL_W-1:0] backed_next;
  csba_status_t       status_next;

  assign off_diff   = {1'b0, addr_q} - {1'b0, window_base};
  assign end_sum    = {1'b0, off_q} + {{(ADDR_W + 1 - LEN_W){1'b0}}, len_q};
  assign end_m1     = end_q[LEN_W-1:0] - LEN_W'(1);
  assign first_full = off_q[LEN_W-1:0] >> chunk_shift;
  assign last_full  = end_m1 >> chunk_shift;
  assign range_now  = win_fail_q || (last_full >= LEN_W'(NUM_CHUNKS));
  assign csize      = CNT_W'(1) << chunk_shift;
  assign cmask      = csize - CNT_W'(1);

  always_comb begin
    if (single_q) begin
      piece = len_q[CNT_W-1:0];
    end else if (idx == first_idx) begin
      piece = pf_q;
    end else if (idx == last_idx) begin
      piece = pl_q;
    end else begin
      piece = csize;
    end
  end

  assign sum_chk = {1'b0, rdata} + {1'b0, piece};

  assign stat.clr_last   = (idx == IDX_W'(NUM_CHUNKS - 1));
  assign stat.range_fail = range_now;
  assign stat.at_last    = (idx == last_idx);
  assign stat.piece_fail = (func_q == FUNC_ADD)
                           ? (sum_chk > {2'b0, chunk_limit})
                           : (rdata < piece);

  assign mem_we = cmd.clr || cmd.wr;
  assign wdata  = cmd.clr ? '0
                : (func_q == FUNC_ADD) ? (rdata + piece) : (rdata - piece);

  assign backed_next = (func_q == FUNC_ADD)
                       ? (backed + {{(TOTAL_W - LEN_W){1'b0}}, len_q})
                       : (backed - {{(TOTAL_W - LEN_W){1'b0}}, len_q});

  always_comb begin
    if (range_fail_q) begin
      status_next = STATUS_RANGE;
    end else if (limit_fail_q) begin
      status_next = STATUS_LIMIT;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[idx] <= wdata;
    end
    rdata <= mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base  <= WINDOW_BASE_RST;
      window_bytes <= WINDOW_BYTES_RST;
      chunk_shift  <= CHUNK_SHIFT_RST;
      chunk_limit  <= CHUNK_LIMIT_RST;
      backed       <= '0;
      idx          <= '0;
    end else begin
      if (cfg_write) begin
        case (csba_reg_t'(cfg_index))
          REG_WINDOW_BASE:  window_base  <= cfg_data[ADDR_W-1:0];
          REG_WINDOW_BYTES: window_bytes <= cfg_data[LEN_W-1:0];
          REG_CHUNK_SHIFT:  chunk_shift  <= cfg_data[SHIFT_W-1:0];
          REG_CHUNK_LIMIT:  chunk_limit  <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr || cmd.idx_inc) begin
        idx <= idx + IDX_W'(1);
      end else if (cmd.calc_idx) begin
        idx <= first_full[IDX_W-1:0];
      end else if (cmd.idx_first) begin
        idx <= first_idx;
      end
      if (cmd.finish && (status_next == STATUS_OK) && with_pa_q) begin
        backed <= backed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q    <= func;
      addr_q    <= seg_addr;
      len_q     <= seg_len;
      with_pa_q <= with_pa;
    end
    if (cmd.calc_off) begin
      off_q      <= off_diff[ADDR_W-1:0];
      lt_base_q  <= off_diff[ADDR_W];
      len_zero_q <= (len_q == '0);
    end
    if (cmd.calc_end) begin
      end_q      <= end_sum;
      win_fail_q <= lt_base_q || len_zero_q
                    || (end_sum > {{(ADDR_W + 1 - LEN_W){1'b0}}, window_bytes});
    end
    if (cmd.calc_idx) begin
      range_fail_q <= range_now;
      limit_fail_q <= 1'b0;
      single_q     <= (first_full == last_full);
      first_idx    <= first_full[IDX_W-1:0];
      last_idx     <= last_full[IDX_W-1:0];
      pf_q         <= csize - (off_q[CNT_W-1:0] & cmask);
      pl_q         <= (end_m1[CNT_W-1:0] & cmask) + CNT_W'(1);
    end
    if (cmd.chk && stat.piece_fail) begin
      limit_fail_q <= 1'b1;
    end
    if (cmd.finish) begin
      status       <= status_next;
      backed_total <= (status_next == STATUS_OK && with_pa_q) ? backed_next : backed;
    end
  end

endmodule
`default_nettype wire

/* hdl/chunked_segment_byte_accounting_core.sv */
`default_nettype none
// Load, offset, window end, chunk index; a segment outside the window or past the
// last chunk then goes to the result, else a check pass (read, compare per chunk;
// stops at an overflow/underflow) and an update pass (read, write per chunk, set by
// the single-port counter memory). A new word is taken only once the result is issued.
// Reset: synchronous; a clearing pass zeroes all NUM_CHUNKS counters before the first
// word is accepted; configuration writes are taken throughout, reset apart.
module chunked_segment_byte_accounting_core #(
  parameter int NUM_CHUNKS = csba_pkg::NUM_CHUNKS_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire [csba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [csba_pkg::CFG_W-1:0]      cfg_data,
  csba_in_if.sink                        in_ch,
  csba_out_if.source                     out_ch
);
  import csba_pkg::*;

  csba_cmd_t  cmd;
  csba_stat_t stat;

  csba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  csba_dp #(
    .NUM_CHUNKS (NUM_CHUNKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (in_ch.func),
    .seg_addr     (in_ch.seg_addr),
    .seg_len      (in_ch.seg_len),
    .with_pa      (in_ch.with_pa),
    .cmd          (cmd),
    .stat         (stat),
    .status       (out_ch.status),
    .backed_total (out_ch.backed_total)
  );

endmodule
`default_nettype wire
